FILE: rtl/gfpm_pkg.sv
// ----------------------------------------------------------------------------
// gfpm_pkg
// Shared types, constants and mod-p helpers for the GF(p^m) arithmetic unit.
// ----------------------------------------------------------------------------
package gfpm_pkg;

  // Fixed widths of the external fields
  localparam int WORD_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W      = 2;

  // Default parameter values
  localparam int DEF_MAX_DEGREE = 8;
  localparam int DEF_COEF_BITS  = 4;

  // A reduced coefficient is below p <= 15
  localparam int LANE_W    = 4;
  // Unreduced lane sum: shifted lane + two products
  localparam int SUM_W     = 2 * LANE_W + 1;
  localparam int MOD_W     = SUM_W + LANE_W;
  // Compare-subtract steps: covers any value below 256 * p
  localparam int MOD_STEPS = 8;
  // Width able to hold a degree up to 16
  localparam int DEG_W     = 5;

  typedef logic [LANE_W-1:0] lane_t;

  // Register reset values
  localparam logic [3:0]        CHAR_P_RST       = 4'd2;
  localparam logic [3:0]        FIELD_DEGREE_RST = 4'd8;
  localparam logic [WORD_W-1:0] MODULUS_LOW_RST  = 32'd69659;
  localparam lane_t             MIN_CHAR_P       = 4'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHAR_P       = 2'd0,
    REG_FIELD_DEGREE = 2'd1,
    REG_MODULUS_LOW  = 2'd2
  } reg_idx_e;

  // Control travelling with a word down the chain
  typedef struct packed {
    logic valid;
    logic is_mul;
  } cell_ctl_t;

  // Reduce a narrow value mod p by restoring compare-subtract
  function automatic lane_t mod_p(input logic [SUM_W-1:0] x, input lane_t p);
    logic [MOD_W-1:0] r;
    logic [MOD_W-1:0] d;
    r = MOD_W'(x);
    d = '0;
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      d = MOD_W'(p) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[LANE_W-1:0];
  endfunction

  // Negate a reduced value mod p
  function automatic lane_t neg_p(input lane_t r, input lane_t p);
    lane_t n;
    n = (r == '0) ? '0 : lane_t'(p - r);
    return n;
  endfunction

  // Add two reduced values mod p
  function automatic lane_t add_p(input lane_t x, input lane_t y, input lane_t p);
    logic [LANE_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) begin
      s = s - {1'b0, p};
    end
    return s[LANE_W-1:0];
  endfunction

endpackage

FILE: rtl/gfpm_cfg.sv
// ----------------------------------------------------------------------------
// gfpm_cfg
// Configuration registers and the values derived from them: effective p,
// lane enables, top-lane select and negated modulus coefficients.
// ----------------------------------------------------------------------------
module gfpm_cfg #(
  parameter int MAX_DEGREE = gfpm_pkg::DEF_MAX_DEGREE,
  parameter int COEF_BITS  = gfpm_pkg::DEF_COEF_BITS
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    wr_en,
  input  logic [gfpm_pkg::CFG_IDX_W-1:0]          wr_index,
  input  logic [gfpm_pkg::WORD_W-1:0]             wr_data,
  output gfpm_pkg::lane_t                         p_eff_r,
  output logic [MAX_DEGREE-1:0]                   lane_en_r,
  output logic [MAX_DEGREE-1:0]                   top_sel_r,
  output gfpm_pkg::lane_t [MAX_DEGREE-1:0]        neg_mod_r
);
  import gfpm_pkg::*;

  localparam int EXT_W = WORD_W + MAX_DEGREE * COEF_BITS;

  logic [3:0]              char_p_r;
  logic [3:0]              field_degree_r;
  logic [WORD_W-1:0]       modulus_low_r;

  lane_t                   p_eff_nxt;
  logic [DEG_W-1:0]        m_eff;
  logic [MAX_DEGREE-1:0]   lane_en_nxt;
  logic [MAX_DEGREE-1:0]   top_sel_nxt;
  lane_t [MAX_DEGREE-1:0]  neg_mod_nxt;
  logic [EXT_W-1:0]        mod_ext;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_p_r       <= CHAR_P_RST;
      field_degree_r <= FIELD_DEGREE_RST;
      modulus_low_r  <= MODULUS_LOW_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CHAR_P:       char_p_r       <= wr_data[3:0];
        REG_FIELD_DEGREE: field_degree_r <= wr_data[3:0];
        REG_MODULUS_LOW:  modulus_low_r  <= wr_data;
        default: ;
      endcase
    end
  end

  // Clamp p and m into their working ranges
  always_comb begin
    p_eff_nxt = (char_p_r < MIN_CHAR_P) ? MIN_CHAR_P : char_p_r;
    if (field_degree_r == '0) begin
      m_eff = DEG_W'(1);
    end else if (DEG_W'(field_degree_r) > DEG_W'(MAX_DEGREE)) begin
      m_eff = DEG_W'(MAX_DEGREE);
    end else begin
      m_eff = DEG_W'(field_degree_r);
    end
  end

  // Lane masks and the negated, reduced modulus
  always_comb begin
    mod_ext = EXT_W'(modulus_low_r);
    for (int i = 0; i < MAX_DEGREE; i++) begin
      lane_en_nxt[i] = (DEG_W'(i) < m_eff);
      top_sel_nxt[i] = (DEG_W'(i + 1) == m_eff);
      neg_mod_nxt[i] = lane_en_nxt[i]
                     ? neg_p(mod_p(SUM_W'(mod_ext[i*COEF_BITS +: COEF_BITS]), p_eff_nxt),
                             p_eff_nxt)
                     : '0;
    end
  end

  // Register the derived values behind the config registers
  always_ff @(posedge clk) begin
    p_eff_r   <= p_eff_nxt;
    lane_en_r <= lane_en_nxt;
    top_sel_r <= top_sel_nxt;
    neg_mod_r <= neg_mod_nxt;
  end

endmodule

FILE: rtl/gfpm_front.sv
// ----------------------------------------------------------------------------
// gfpm_front
// Input capture, lane unpacking and mod-p reduction, and the seed word for
// the cell chain (add/subtract result, or zero for multiply).
// ----------------------------------------------------------------------------
module gfpm_front #(
  parameter int MAX_DEGREE = gfpm_pkg::DEF_MAX_DEGREE,
  parameter int COEF_BITS  = gfpm_pkg::DEF_COEF_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               accept,
  input  logic [gfpm_pkg::OP_W-1:0]          operation,
  input  logic [gfpm_pkg::WORD_W-1:0]        operand_a,
  input  logic [gfpm_pkg::WORD_W-1:0]        operand_b,
  input  gfpm_pkg::lane_t                    p_eff,
  input  logic [MAX_DEGREE-1:0]              lane_en,
  output gfpm_pkg::cell_ctl_t                ctl_out,
  output gfpm_pkg::lane_t [MAX_DEGREE-1:0]   a_out,
  output gfpm_pkg::lane_t [MAX_DEGREE-1:0]   b_out,
  output gfpm_pkg::lane_t [MAX_DEGREE-1:0]   acc_out
);
  import gfpm_pkg::*;

  localparam int EXT_W = WORD_W + MAX_DEGREE * COEF_BITS;

  logic                    v0_r;
  logic [OP_W-1:0]         op0_r;
  logic [WORD_W-1:0]       a0_r;
  logic [WORD_W-1:0]       b0_r;

  logic                    v1_r;
  logic [OP_W-1:0]         op1_r;
  lane_t [MAX_DEGREE-1:0]  a1_r;
  lane_t [MAX_DEGREE-1:0]  b1_r;
  lane_t [MAX_DEGREE-1:0]  a1_nxt;
  lane_t [MAX_DEGREE-1:0]  b1_nxt;
  logic [EXT_W-1:0]        a_ext;
  logic [EXT_W-1:0]        b_ext;

  // Capture the raw word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op0_r <= operation;
      a0_r  <= operand_a;
      b0_r  <= operand_b;
    end
  end

  // Unpack lanes, drop lanes at or above m, reduce mod p
  always_comb begin
    a_ext = EXT_W'(a0_r);
    b_ext = EXT_W'(b0_r);
    for (int i = 0; i < MAX_DEGREE; i++) begin
      a1_nxt[i] = lane_en[i] ? mod_p(SUM_W'(a_ext[i*COEF_BITS +: COEF_BITS]), p_eff) : '0;
      b1_nxt[i] = lane_en[i] ? mod_p(SUM_W'(b_ext[i*COEF_BITS +: COEF_BITS]), p_eff) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    op1_r <= op0_r;
    a1_r  <= a1_nxt;
    b1_r  <= b1_nxt;
  end

  // Seed the chain: add/subtract finish here, multiply starts from zero
  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      unique case (op1_r)
        OP_ADD:  acc_out[i] = add_p(a1_r[i], b1_r[i], p_eff);
        OP_SUB:  acc_out[i] = add_p(a1_r[i], neg_p(b1_r[i], p_eff), p_eff);
        default: acc_out[i] = '0;
      endcase
    end
  end

  assign ctl_out.valid  = v1_r;
  assign ctl_out.is_mul = (op1_r == OP_MUL);
  assign a_out          = a1_r;
  assign b_out          = b1_r;

endmodule

FILE: rtl/gfpm_cell.sv
// ----------------------------------------------------------------------------
// gfpm_cell
// One Horner step of the product: acc <- acc * x mod f + a * b[B_IDX].
// Two register stages: products and lane sums, then mod-p reduction.
// Non-multiply words pass through unchanged.
// ----------------------------------------------------------------------------
module gfpm_cell #(
  parameter int MAX_DEGREE = gfpm_pkg::DEF_MAX_DEGREE,
  parameter int B_IDX      = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gfpm_pkg::lane_t                    p_eff,
  input  logic [MAX_DEGREE-1:0]              lane_en,
  input  logic [MAX_DEGREE-1:0]              top_sel,
  input  gfpm_pkg::lane_t [MAX_DEGREE-1:0]   neg_mod,
  input  gfpm_pkg::cell_ctl_t                ctl_in,
  input  gfpm_pkg::lane_t [MAX_DEGREE-1:0]   a_in,
  input  gfpm_pkg::lane_t [MAX_DEGREE-1:0]   b_in,
  input  gfpm_pkg::lane_t [MAX_DEGREE-1:0]   acc_in,
  output gfpm_pkg::cell_ctl_t                ctl_out_r,
  output gfpm_pkg::lane_t [MAX_DEGREE-1:0]   a_out_r,
  output gfpm_pkg::lane_t [MAX_DEGREE-1:0]   b_out_r,
  output gfpm_pkg::lane_t [MAX_DEGREE-1:0]   acc_out_r
);
  import gfpm_pkg::*;

  lane_t                        top_coef;
  lane_t [MAX_DEGREE-1:0]       shifted;
  logic  [2*LANE_W-1:0]         prod_ab [MAX_DEGREE];
  logic  [2*LANE_W-1:0]         prod_fb [MAX_DEGREE];
  logic  [SUM_W-1:0]            sum_nxt [MAX_DEGREE];

  cell_ctl_t                    ctl_a_r;
  lane_t [MAX_DEGREE-1:0]       a_a_r;
  lane_t [MAX_DEGREE-1:0]       b_a_r;
  logic  [SUM_W-1:0]            sum_a_r [MAX_DEGREE];
  lane_t [MAX_DEGREE-1:0]       acc_nxt;

  // Pick the coefficient of degree m-1
  always_comb begin
    top_coef = '0;
    for (int i = 0; i < MAX_DEGREE; i++) begin
      top_coef = top_coef | (acc_in[i] & {LANE_W{top_sel[i]}});
    end
  end

  // Shift up by one degree
  for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_shift
    if (i == 0) begin : g_low
      assign shifted[i] = '0;
    end else begin : g_up
      assign shifted[i] = acc_in[i-1];
    end
  end

  // Products and unreduced lane sums
  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      prod_ab[i] = a_in[i] * b_in[B_IDX];
      prod_fb[i] = top_coef * neg_mod[i];
      if (!ctl_in.is_mul) begin
        sum_nxt[i] = SUM_W'(acc_in[i]);
      end else if (lane_en[i]) begin
        sum_nxt[i] = SUM_W'(shifted[i]) + SUM_W'(prod_ab[i]) + SUM_W'(prod_fb[i]);
      end else begin
        sum_nxt[i] = '0;
      end
    end
  end

  // Stage A: hold sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else begin
      ctl_a_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    a_a_r   <= a_in;
    b_a_r   <= b_in;
    sum_a_r <= sum_nxt;
  end

  // Reduce each lane mod p
  always_comb begin
    for (int i = 0; i < MAX_DEGREE; i++) begin
      acc_nxt[i] = mod_p(sum_a_r[i], p_eff);
    end
  end

  // Stage B: hand the word to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_out_r <= '0;
    end else begin
      ctl_out_r <= ctl_a_r;
    end
  end

  always_ff @(posedge clk) begin
    a_out_r   <= a_a_r;
    b_out_r   <= b_a_r;
    acc_out_r <= acc_nxt;
  end

endmodule

FILE: rtl/gf_pm_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// gf_pm_arithmetic_unit_top
// GF(p^m) add, subtract and multiply in polynomial basis, coefficients in
// fixed COEF_BITS lanes. Multiply runs MSB-first Horner steps with interleaved
// reduction along a chain of MAX_DEGREE cells.
//
//   channel  ports                                   handshake
//   -------  --------------------------------------  ------------------------
//   input    in_operation, in_operand_a/b             start && !busy
//   result   out_result_value                         out_valid, one cycle
//   config   cfg_index, cfg_data                      cfg_valid && cfg_ready
//
// A new word is taken every cycle while busy is low. Each result strobes after
// the capture and lane-reduction registers, the cell chain with two register
// stages per coefficient of operand b, and the output register. Results leave
// in input order.
// Reset is synchronous, active low; busy is high through reset and until the
// first clock edge after it. The receiver cannot stall, so the chain never holds.
// ----------------------------------------------------------------------------
module gf_pm_arithmetic_unit_top #(
  parameter int MAX_DEGREE = gfpm_pkg::DEF_MAX_DEGREE,
  parameter int COEF_BITS  = gfpm_pkg::DEF_COEF_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [gfpm_pkg::OP_W-1:0]         in_operation,
  input  logic [gfpm_pkg::WORD_W-1:0]       in_operand_a,
  input  logic [gfpm_pkg::WORD_W-1:0]       in_operand_b,
  output logic                              out_valid,
  output logic [gfpm_pkg::WORD_W-1:0]       out_result_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gfpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gfpm_pkg::WORD_W-1:0]       cfg_data
);
  import gfpm_pkg::*;

  localparam int PACK_W  = WORD_W + MAX_DEGREE * COEF_BITS;
  localparam int LATENCY = 2 * MAX_DEGREE + 3;

  logic                    ready_r;
  logic                    accept;

  lane_t                   p_eff;
  logic [MAX_DEGREE-1:0]   lane_en;
  logic [MAX_DEGREE-1:0]   top_sel;
  lane_t [MAX_DEGREE-1:0]  neg_mod;

  cell_ctl_t               ctl_ch [MAX_DEGREE+1];
  lane_t [MAX_DEGREE-1:0]  a_ch   [MAX_DEGREE+1];
  lane_t [MAX_DEGREE-1:0]  b_ch   [MAX_DEGREE+1];
  lane_t [MAX_DEGREE-1:0]  acc_ch [MAX_DEGREE+1];

  logic [PACK_W-1:0]       packed_nxt;
  logic                    out_valid_r;
  logic [WORD_W-1:0]       out_value_r;

  // Raise ready through a register after reset so derived config is settled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= 1'b0;
    end else begin
      ready_r <= 1'b1;
    end
  end

  assign busy      = !ready_r;
  assign cfg_ready = ready_r;
  assign accept    = start && ready_r;

  gfpm_cfg #(
    .MAX_DEGREE (MAX_DEGREE),
    .COEF_BITS  (COEF_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && ready_r),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .p_eff_r   (p_eff),
    .lane_en_r (lane_en),
    .top_sel_r (top_sel),
    .neg_mod_r (neg_mod)
  );

  gfpm_front #(
    .MAX_DEGREE (MAX_DEGREE),
    .COEF_BITS  (COEF_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_operation),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .p_eff     (p_eff),
    .lane_en   (lane_en),
    .ctl_out   (ctl_ch[0]),
    .a_out     (a_ch[0]),
    .b_out     (b_ch[0]),
    .acc_out   (acc_ch[0])
  );

  // Cell k consumes coefficient MAX_DEGREE-1-k of operand b
  for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_cell
    gfpm_cell #(
      .MAX_DEGREE (MAX_DEGREE),
      .B_IDX      (MAX_DEGREE - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .p_eff     (p_eff),
      .lane_en   (lane_en),
      .top_sel   (top_sel),
      .neg_mod   (neg_mod),
      .ctl_in    (ctl_ch[k]),
      .a_in      (a_ch[k]),
      .b_in      (b_ch[k]),
      .acc_in    (acc_ch[k]),
      .ctl_out_r (ctl_ch[k+1]),
      .a_out_r   (a_ch[k+1]),
      .b_out_r   (b_ch[k+1]),
      .acc_out_r (acc_ch[k+1])
    );
  end

  // Pack lanes back into the result word
  always_comb begin
    packed_nxt = '0;
    for (int i = 0; i < MAX_DEGREE; i++) begin
      packed_nxt[i*COEF_BITS +: COEF_BITS] = COEF_BITS'(acc_ch[MAX_DEGREE][i]);
    end
  end

  // Output register and strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_ch[MAX_DEGREE].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= packed_nxt[WORD_W-1:0];
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;

  // Every accepted word strobes out after passing through the whole chain
  a_word_delivered: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("accepted word did not reach the output on time");

  // No strobe without a word accepted at the matching edge
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted word");

endmodule
